FILE: rtl/core/c_subset_lexical_scanner_macros.svh
// Assertion macros for the scanner's RTL; the token queue is the file that uses them.
`ifndef C_SUBSET_LEXICAL_SCANNER_MACROS_SVH
`define C_SUBSET_LEXICAL_SCANNER_MACROS_SVH
`ifndef SYNTHESIS
`define CSLS_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define CSLS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define CSLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CSLS_ASSERT(lbl, cond, msg)
`define CSLS_ASSERT_IMP(lbl, ante, cons, msg)
`define CSLS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/core/csls_pkg.sv
// Types, constants and tables shared by the scanner modules.
`timescale 1ns / 1ps
package csls_pkg;

  localparam int MAX_LEXEME = 32;
  localparam int LEN_W      = 6;
  localparam int NUM_WORDS  = 17;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  localparam logic [4:0] WORD_NONE = 5'd17;
  localparam logic [4:0] WORD_FIRST_TYPE = 5'd13;
  localparam logic [17:0] HASH_MAX = 18'h3FFFF;
  localparam logic [15:0] POS_MAX = 16'hFFFF;

  localparam logic [3:0] KIND_REL     = 4'd0;
  localparam logic [3:0] KIND_ASSIGN  = 4'd1;
  localparam logic [3:0] KIND_ARITH   = 4'd2;
  localparam logic [3:0] KIND_LOGIC   = 4'd3;
  localparam logic [3:0] KIND_SPECIAL = 4'd4;
  localparam logic [3:0] KIND_NUM     = 4'd5;
  localparam logic [3:0] KIND_STRING  = 4'd6;
  localparam logic [3:0] KIND_IDENT   = 4'd7;
  localparam logic [3:0] KIND_KEYWORD = 4'd8;
  localparam logic [3:0] KIND_TYPE    = 4'd9;
  localparam logic [3:0] KIND_NEWLINE = 4'd10;
  localparam logic [3:0] KIND_END     = 4'd11;

  typedef enum logic [3:0] {
    MODE_IDLE, MODE_ADDSUB, MODE_MULMOD, MODE_SLASH, MODE_ANDOR, MODE_BANG,
    MODE_LTGT, MODE_EQ, MODE_NUM, MODE_IDENT, MODE_STR, MODE_LINE,
    MODE_BLOCK, MODE_BSTAR
  } mode_t;

  typedef struct packed {
    logic [3:0]       kind;
    logic [15:0]      start_row;
    logic [15:0]      start_col;
    logic [LEN_W-1:0] lexeme_length;
    logic [7:0]       first_char;
    logic [7:0]       second_char;
    logic [4:0]       word_index;
    logic [31:0]      number_value;
    logic [17:0]      name_hash;
    logic             too_long;
    logic             last_of_run;
  } tok_t;

  typedef struct packed {
    logic [1:0] cnt;
  } push_t;

  function automatic tok_t tok_blank();
    tok_t t;
    t = '0;
    t.word_index = WORD_NONE;
    return t;
  endfunction

  function automatic logic [LEN_W-1:0] word_len(input logic [4:0] w);
    case (w)
      5'd0: return 6'd4;   5'd1: return 6'd2;   5'd2: return 6'd6;
      5'd3: return 6'd5;   5'd4: return 6'd4;   5'd5: return 6'd3;
      5'd6: return 6'd5;   5'd7: return 6'd4;   5'd8: return 6'd2;
      5'd9: return 6'd6;   5'd10: return 6'd4;  5'd11: return 6'd5;
      5'd12: return 6'd6;  5'd13: return 6'd3;  5'd14: return 6'd5;
      5'd15: return 6'd6;  5'd16: return 6'd4;
      default: return 6'd0;
    endcase
  endfunction

  // Character of keyword w at position p, zero past its end.
  function automatic logic [7:0] word_char(input logic [4:0] w, input logic [LEN_W-1:0] p);
    logic [47:0] txt;
    case (w)
      5'd0:  txt = "sqrt";
      5'd1:  txt = "if";
      5'd2:  txt = "printf";
      5'd3:  txt = "scanf";
      5'd4:  txt = "else";
      5'd5:  txt = "for";
      5'd6:  txt = "while";
      5'd7:  txt = "void";
      5'd8:  txt = "do";
      5'd9:  txt = "switch";
      5'd10: txt = "case";
      5'd11: txt = "break";
      5'd12: txt = "return";
      5'd13: txt = "int";
      5'd14: txt = "float";
      5'd15: txt = "double";
      5'd16: txt = "char";
      default: txt = '0;
    endcase
    if (p >= word_len(w)) return 8'd0;
    return txt[8*(word_len(w) - p - 6'd1) +: 8];
  endfunction

  function automatic logic [8:0] prime_at(input logic [5:0] p);
    case (p)
      6'd0: return 9'd2;    6'd1: return 9'd3;    6'd2: return 9'd5;    6'd3: return 9'd7;
      6'd4: return 9'd11;   6'd5: return 9'd13;   6'd6: return 9'd17;   6'd7: return 9'd19;
      6'd8: return 9'd23;   6'd9: return 9'd29;   6'd10: return 9'd31;  6'd11: return 9'd37;
      6'd12: return 9'd41;  6'd13: return 9'd43;  6'd14: return 9'd47;  6'd15: return 9'd53;
      6'd16: return 9'd59;  6'd17: return 9'd61;  6'd18: return 9'd67;  6'd19: return 9'd71;
      6'd20: return 9'd73;  6'd21: return 9'd79;  6'd22: return 9'd83;  6'd23: return 9'd89;
      6'd24: return 9'd97;  6'd25: return 9'd101; 6'd26: return 9'd103; 6'd27: return 9'd107;
      6'd28: return 9'd109; 6'd29: return 9'd113; 6'd30: return 9'd127; 6'd31: return 9'd131;
      6'd32: return 9'd137; 6'd33: return 9'd139; 6'd34: return 9'd149; 6'd35: return 9'd151;
      6'd36: return 9'd157; 6'd37: return 9'd163; 6'd38: return 9'd167; 6'd39: return 9'd173;
      6'd40: return 9'd179; 6'd41: return 9'd181; 6'd42: return 9'd191; 6'd43: return 9'd193;
      6'd44: return 9'd197; 6'd45: return 9'd199; 6'd46: return 9'd211; 6'd47: return 9'd223;
      6'd48: return 9'd227; 6'd49: return 9'd229; 6'd50: return 9'd233; 6'd51: return 9'd239;
      6'd52: return 9'd241; 6'd53: return 9'd251; 6'd54: return 9'd257; 6'd55: return 9'd263;
      6'd56: return 9'd269; 6'd57: return 9'd271; 6'd58: return 9'd277; 6'd59: return 9'd281;
      6'd60: return 9'd283; 6'd61: return 9'd293; 6'd62: return 9'd307; 6'd63: return 9'd311;
      default: return 9'd0;
    endcase
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

endpackage

FILE: rtl/core/c_subset_lexical_scanner.sv
// Top level of the C subset lexical scanner: configuration register and the three stages.
`timescale 1ns / 1ps
// The scanner takes one source byte per cycle while in_ready is high and emits tokens
// on the output channel, one word per cycle while out_ready is high. An input word is
// accepted whenever the token queue has room for two tokens, so with the output free a
// stream in which each byte gives at most one token runs at one byte per cycle; a byte
// that closes one token and opens another gives two tokens, which leave one word at a
// time. The scanner state is updated as each byte is accepted; with the queue empty and
// the output free, a token is written to the queue as the byte that completes it is
// accepted, then goes through the output register. tab_width is written through its own
// channel, which is always ready, and should be written only while the block is idle.
module c_subset_lexical_scanner (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  tab_width,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  ch,
  input  logic        end_of_input,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  kind,
  output logic [15:0] start_row,
  output logic [15:0] start_col,
  output logic [5:0]  lexeme_length,
  output logic [7:0]  first_char,
  output logic [7:0]  second_char,
  output logic [4:0]  word_index,
  output logic [31:0] number_value,
  output logic [17:0] name_hash,
  output logic        too_long,
  output logic        last_of_run
);
  import csls_pkg::*;

  logic [3:0] tab_w;
  logic take, room, nonempty, pop;
  push_t push;
  tok_t slot0, slot1, head, out_tok;

  assign cfg_ready = 1'b1;
  assign in_ready = room;
  assign take = in_valid && room;

  always_ff @(posedge clk) begin
    if (rst) tab_w <= 4'd4;
    else if (cfg_valid) tab_w <= tab_width;
  end

  csls_front u_front (
    .clk, .rst, .take, .ch, .end_of_input, .tab_w, .push, .slot0, .slot1
  );

  csls_queue u_queue (
    .clk, .rst, .push, .slot0, .slot1, .pop, .room, .nonempty, .head
  );

  csls_back u_back (
    .clk, .rst, .nonempty, .head, .pop, .out_valid, .out_ready, .out_tok
  );

  assign kind          = out_tok.kind;
  assign start_row     = out_tok.start_row;
  assign start_col     = out_tok.start_col;
  assign lexeme_length = out_tok.lexeme_length;
  assign first_char    = out_tok.first_char;
  assign second_char   = out_tok.second_char;
  assign word_index    = out_tok.word_index;
  assign number_value  = out_tok.number_value;
  assign name_hash     = out_tok.name_hash;
  assign too_long      = out_tok.too_long;
  assign last_of_run   = out_tok.last_of_run;

endmodule

FILE: rtl/core/csls_front.sv
// Front end: scanner state machine, turns one byte per cycle, when take is high, into up to two tokens.
`timescale 1ns / 1ps
module csls_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  logic [7:0]           ch,
  input  logic                 end_of_input,
  input  logic [3:0]           tab_w,
  output csls_pkg::push_t      push,
  output csls_pkg::tok_t       slot0,
  output csls_pkg::tok_t       slot1
);
  import csls_pkg::*;

  mode_t            mode, mode_next;
  logic [15:0]      cur_row, cur_row_next, cur_col, cur_col_next;
  logic [15:0]      tok_row, tok_row_next, tok_col, tok_col_next;
  logic [LEN_W-1:0] tok_len, tok_len_next;
  logic [7:0]       held_char, held_char_next;
  logic [31:0]      num_acc, num_acc_next;
  logic [17:0]      hash_acc, hash_acc_next;
  logic [NUM_WORDS-1:0] word_alive, word_alive_next;
  logic             overflow_flag, overflow_flag_next;

  logic flush_v;
  tok_t flush_tok;
  logic [4:0] found;

  // Token left pending by the current state, as it would be flushed.
  always_comb begin
    flush_v = 1'b1;
    flush_tok = tok_blank();
    flush_tok.start_row = tok_row;
    flush_tok.start_col = tok_col;
    flush_tok.lexeme_length = 6'd1;
    flush_tok.first_char = held_char;
    found = WORD_NONE;
    for (int w = NUM_WORDS - 1; w >= 0; w--) begin
      if (word_alive[w] && (word_len(5'(w)) == tok_len)) found = 5'(w);
    end
    if (overflow_flag) found = WORD_NONE;
    case (mode)
      MODE_ADDSUB, MODE_MULMOD, MODE_SLASH: flush_tok.kind = KIND_ARITH;
      MODE_ANDOR, MODE_BANG: flush_tok.kind = KIND_LOGIC;
      MODE_LTGT: flush_tok.kind = KIND_REL;
      MODE_EQ: flush_tok.kind = KIND_ASSIGN;
      MODE_NUM: begin
        flush_tok.kind = KIND_NUM;
        flush_tok.lexeme_length = tok_len;
        flush_tok.number_value = num_acc;
        flush_tok.too_long = overflow_flag;
      end
      MODE_IDENT: begin
        flush_tok.lexeme_length = tok_len;
        flush_tok.too_long = overflow_flag;
        if (found == WORD_NONE) begin
          flush_tok.kind = KIND_IDENT;
          flush_tok.name_hash = hash_acc;
        end else begin
          flush_tok.kind = (found < WORD_FIRST_TYPE) ? KIND_KEYWORD : KIND_TYPE;
          flush_tok.word_index = found;
        end
      end
      MODE_STR: begin
        flush_tok.kind = KIND_STRING;
        flush_tok.lexeme_length = tok_len;
        flush_tok.first_char = 8'h22;
        flush_tok.too_long = overflow_flag;
      end
      default: flush_v = 1'b0;
    endcase
  end

  logic a_v, b_v, do_flush, do_start, op_v, str_grow, cont_d, cont_i;
  logic add_d, add_i;
  logic [3:0] op_kind;
  tok_t a_tok, b_tok;
  logic [LEN_W-1:0] base_len;
  logic [31:0] base_num;
  logic [17:0] base_hash;
  logic [NUM_WORDS-1:0] base_alive, match;
  logic [35:0] num_wide;
  logic [18:0] hash_wide;
  logic [16:0] col_sum;

  always_comb begin
    mode_next = mode;
    cur_row_next = cur_row;
    cur_col_next = cur_col;
    tok_row_next = tok_row;
    tok_col_next = tok_col;
    tok_len_next = tok_len;
    held_char_next = held_char;
    num_acc_next = num_acc;
    hash_acc_next = hash_acc;
    word_alive_next = word_alive;
    overflow_flag_next = overflow_flag;
    a_v = 1'b0; b_v = 1'b0;
    a_tok = tok_blank(); b_tok = tok_blank();
    do_flush = 1'b0; do_start = 1'b0; op_v = 1'b0; op_kind = KIND_ARITH;
    str_grow = 1'b0; cont_d = 1'b0; cont_i = 1'b0;
    base_len = '0; base_num = '0; base_hash = '0; base_alive = '1;
    match = '0; num_wide = '0; hash_wide = '0; col_sum = '0;
    add_d = 1'b0; add_i = 1'b0;

    if (end_of_input) begin
      do_flush = 1'b1;
    end else begin
      case (mode)
        MODE_IDLE: do_start = 1'b1;
        MODE_ADDSUB: begin
          if (ch == held_char || ch == "=") op_v = 1'b1;
          else begin do_flush = 1'b1; do_start = 1'b1; end
        end
        MODE_MULMOD: begin
          if (ch == "=") op_v = 1'b1;
          else begin do_flush = 1'b1; do_start = 1'b1; end
        end
        MODE_SLASH: begin
          if (ch == "/") mode_next = MODE_LINE;
          else if (ch == "*") mode_next = MODE_BLOCK;
          else if (ch == "=") op_v = 1'b1;
          else begin do_flush = 1'b1; do_start = 1'b1; end
        end
        MODE_ANDOR: begin
          op_kind = KIND_LOGIC;
          if (ch == held_char) op_v = 1'b1;
          else begin do_flush = 1'b1; do_start = 1'b1; end
        end
        MODE_BANG, MODE_LTGT, MODE_EQ: begin
          op_kind = KIND_REL;
          if (ch == "=") op_v = 1'b1;
          else begin do_flush = 1'b1; do_start = 1'b1; end
        end
        MODE_NUM: begin
          if (is_digit(ch)) cont_d = 1'b1;
          else begin do_flush = 1'b1; do_start = 1'b1; end
        end
        MODE_IDENT: begin
          if (is_digit(ch) || is_alpha(ch) || ch == "_") cont_i = 1'b1;
          else begin do_flush = 1'b1; do_start = 1'b1; end
        end
        MODE_STR: begin
          if (ch == 8'h22) do_flush = 1'b1;
          else str_grow = 1'b1;
        end
        MODE_LINE: if (ch == 8'h0A) mode_next = MODE_IDLE;
        MODE_BLOCK: if (ch == "*") mode_next = MODE_BSTAR;
        MODE_BSTAR: begin
          if (ch == "/") mode_next = MODE_IDLE;
          else if (ch != "*") mode_next = MODE_BLOCK;
        end
        default: do_start = 1'b1;
      endcase
    end

    if (op_v) begin
      a_v = 1'b1;
      a_tok = tok_blank();
      a_tok.kind = op_kind;
      a_tok.start_row = tok_row;
      a_tok.start_col = tok_col;
      a_tok.lexeme_length = 6'd2;
      a_tok.first_char = held_char;
      a_tok.second_char = ch;
      mode_next = MODE_IDLE;
    end
    if (do_flush) begin
      a_v = flush_v;
      a_tok = flush_tok;
      mode_next = MODE_IDLE;
    end
    if (str_grow) begin
      if (tok_len < 6'(MAX_LEXEME)) tok_len_next = tok_len + 6'd1;
      else overflow_flag_next = 1'b1;
    end

    if (do_start) begin
      tok_row_next = cur_row;
      tok_col_next = cur_col;
      held_char_next = ch;
      tok_len_next = '0;
      num_acc_next = '0;
      hash_acc_next = '0;
      word_alive_next = '1;
      overflow_flag_next = 1'b0;
      mode_next = MODE_IDLE;
      b_tok.start_row = cur_row;
      b_tok.start_col = cur_col;
      b_tok.lexeme_length = 6'd1;
      b_tok.first_char = ch;
      case (ch)
        8'h0A: begin b_v = 1'b1; b_tok.kind = KIND_NEWLINE; end
        "/": mode_next = MODE_SLASH;
        "#": mode_next = MODE_LINE;
        8'h22: mode_next = MODE_STR;
        ";", ",", ":", "(", ")", "{", "}", "[", "]": begin
          b_v = 1'b1;
          b_tok.kind = KIND_SPECIAL;
        end
        "+", "-": mode_next = MODE_ADDSUB;
        "*", "%": mode_next = MODE_MULMOD;
        "&", "|": mode_next = MODE_ANDOR;
        "!": mode_next = MODE_BANG;
        "<", ">": mode_next = MODE_LTGT;
        "=": mode_next = MODE_EQ;
        default: begin
          if (is_digit(ch)) begin
            mode_next = MODE_NUM;
            add_d = 1'b1;
          end else if (is_alpha(ch) || ch == "_") begin
            mode_next = MODE_IDENT;
            add_i = 1'b1;
          end
        end
      endcase
    end

    // A new lexeme grows from cleared accumulators, a running one from the registers.
    if (!do_start) begin
      base_len = tok_len;
      base_num = num_acc;
      base_hash = hash_acc;
      base_alive = word_alive;
    end
    if (add_d || cont_d) begin
      num_wide = {1'b0, base_num, 3'b000} + {3'b000, base_num, 1'b0} + {28'd0, ch - "0"};
      if (base_len < 6'(MAX_LEXEME)) tok_len_next = base_len + 6'd1;
      else overflow_flag_next = 1'b1;
      if (num_wide[35:32] != 4'd0) begin
        num_acc_next = '1;
        overflow_flag_next = 1'b1;
      end else begin
        num_acc_next = num_wide[31:0];
      end
    end
    if (add_i || cont_i) begin
      for (int w = 0; w < NUM_WORDS; w++) begin
        match[w] = (word_char(5'(w), base_len) == ch);
      end
      hash_wide = {1'b0, base_hash} + (19'(ch) * 19'(prime_at(base_len)));
      if (base_len >= 6'(MAX_LEXEME)) begin
        overflow_flag_next = 1'b1;
        word_alive_next = '0;
      end else begin
        tok_len_next = base_len + 6'd1;
        word_alive_next = base_alive & match;
        hash_acc_next = hash_wide[18] ? HASH_MAX : hash_wide[17:0];
      end
    end

    if (end_of_input) begin
      b_v = 1'b1;
      b_tok = tok_blank();
      b_tok.kind = KIND_END;
      b_tok.start_row = cur_row;
      b_tok.start_col = cur_col;
      b_tok.lexeme_length = '0;
      mode_next = MODE_IDLE;
      cur_row_next = 16'd1; cur_col_next = 16'd1;
      tok_row_next = 16'd1; tok_col_next = 16'd1;
      tok_len_next = '0; held_char_next = '0; num_acc_next = '0;
      hash_acc_next = '0; word_alive_next = '1; overflow_flag_next = 1'b0;
    end else if (ch == 8'h0A) begin
      if (cur_row != POS_MAX) cur_row_next = cur_row + 16'd1;
      cur_col_next = 16'd1;
    end else begin
      col_sum = {1'b0, cur_col} + ((ch == 8'h09) ? {13'd0, tab_w} : 17'd1);
      cur_col_next = col_sum[16] ? POS_MAX : col_sum[15:0];
    end
  end

  always_comb begin
    push.cnt = '0;
    slot0 = b_tok;
    slot1 = b_tok;
    slot0.last_of_run = 1'b1;
    slot1.last_of_run = 1'b1;
    if (a_v) begin
      slot0 = a_tok;
      slot0.last_of_run = !b_v;
    end
    if (take) push.cnt = 2'({1'b0, a_v} + {1'b0, b_v});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
      cur_row <= 16'd1; cur_col <= 16'd1;
      tok_row <= 16'd1; tok_col <= 16'd1;
      tok_len <= '0; held_char <= '0; num_acc <= '0; hash_acc <= '0;
      word_alive <= '1; overflow_flag <= 1'b0;
    end else if (take) begin
      mode <= mode_next;
      cur_row <= cur_row_next; cur_col <= cur_col_next;
      tok_row <= tok_row_next; tok_col <= tok_col_next;
      tok_len <= tok_len_next; held_char <= held_char_next;
      num_acc <= num_acc_next; hash_acc <= hash_acc_next;
      word_alive <= word_alive_next; overflow_flag <= overflow_flag_next;
    end
  end

endmodule

FILE: rtl/core/csls_queue.sv
// Token queue between scanner and output stage: up to two writes and one read per cycle.
`timescale 1ns / 1ps
`include "c_subset_lexical_scanner_macros.svh"
module csls_queue (
  input  logic             clk,
  input  logic             rst,
  input  csls_pkg::push_t  push,
  input  csls_pkg::tok_t   slot0,
  input  csls_pkg::tok_t   slot1,
  input  logic             pop,
  output logic             room,
  output logic             nonempty,
  output csls_pkg::tok_t   head
);
  import csls_pkg::*;

  tok_t entry [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic [Q_PTR_W-1:0] wr_ptr_1;

  assign wr_ptr_1 = wr_ptr + Q_PTR_W'(1);
  assign room = (count <= Q_CNT_W'(Q_DEPTH - 2));
  assign nonempty = (count != '0);
  assign head = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) entry[wr_ptr] <= slot0;
    if (push.cnt == 2'd2) entry[wr_ptr_1] <= slot1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= wr_ptr + Q_PTR_W'(push.cnt);
      if (pop) rd_ptr <= rd_ptr + Q_PTR_W'(1);
      count <= count + Q_CNT_W'(push.cnt) - Q_CNT_W'(pop);
    end
  end

  `CSLS_ASSERT(a_count_bound, count <= Q_CNT_W'(Q_DEPTH), "token queue count beyond depth")
  `CSLS_ASSERT_IMP(a_no_overrun, push.cnt != 2'd0, count <= Q_CNT_W'(Q_DEPTH - 2), "token queue overrun")
  `CSLS_ASSERT_IMP(a_no_underrun, pop, count != '0, "token queue read while empty")
  `CSLS_ASSERT_NEXT(a_idle_hold, push.cnt == 2'd0 && !pop, $stable(count), "queue count moved while idle")

endmodule

FILE: rtl/core/csls_back.sv
// Back end: output register that takes tokens from the queue one word at a time.
`timescale 1ns / 1ps
module csls_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            nonempty,
  input  csls_pkg::tok_t  head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output csls_pkg::tok_t  out_tok
);
  import csls_pkg::*;

  assign pop = nonempty && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) out_tok <= head;
  end

endmodule

FILE: sim/c_subset_lexical_scanner_test.sv
// Self-checking testbench for the C subset lexical scanner.
`timescale 1ns / 1ps
module c_subset_lexical_scanner_test;
  import csls_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
  } src_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  tab_width = 4'd4;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  ch = 8'd0;
  logic        end_of_input = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  kind;
  logic [15:0] start_row;
  logic [15:0] start_col;
  logic [5:0]  lexeme_length;
  logic [7:0]  first_char;
  logic [7:0]  second_char;
  logic [4:0]  word_index;
  logic [31:0] number_value;
  logic [17:0] name_hash;
  logic        too_long;
  logic        last_of_run;

  c_subset_lexical_scanner dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .tab_width(tab_width),
    .in_valid(in_valid), .in_ready(in_ready), .ch(ch), .end_of_input(end_of_input),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .start_row(start_row), .start_col(start_col),
    .lexeme_length(lexeme_length), .first_char(first_char), .second_char(second_char),
    .word_index(word_index), .number_value(number_value), .name_hash(name_hash),
    .too_long(too_long), .last_of_run(last_of_run)
  );

  always #5 clk = ~clk;

  // Scanner state mirrored by the token predictor.
  logic [3:0]  tabs_now = 4'd4;
  mode_t       p_mode;
  logic [15:0] p_row, p_col, t_row, t_col;
  logic [5:0]  t_len;
  logic [7:0]  t_first;
  logic [31:0] t_num;
  logic [17:0] t_hash;
  logic [16:0] t_alive;
  logic        t_over;

  src_byte_t   byte_queue[$];
  tok_t        token_queue[$];
  tok_t        step_toks[$];
  int          n_bad = 0;
  bit          idle_free = 1'b0;
  bit          cfg_pending = 1'b0;
  logic [3:0]  cfg_value = 4'd4;

  string kw_names[17] = '{"sqrt", "if", "printf", "scanf", "else", "for", "while",
    "void", "do", "switch", "case", "break", "return", "int", "float", "double", "char"};
  int primes_tab[64] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47, 53,
    59, 61, 67, 71, 73, 79, 83, 89, 97, 101, 103, 107, 109, 113, 127, 131,
    137, 139, 149, 151, 157, 163, 167, 173, 179, 181, 191, 193, 197, 199, 211, 223,
    227, 229, 233, 239, 241, 251, 257, 263, 269, 271, 277, 281, 283, 293, 307, 311};
  string id_chars  = "_0aA";
  string op_chars  = "+-*%&|!<>=/";
  string sym_chars = ";,:(){}[]";
  string op2_chars = "=+-&|";

  function automatic bit digit_c(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit word_c(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || digit_c(c) || c == "_";
  endfunction

  task automatic emit(logic [3:0] k, logic [15:0] r, logic [15:0] c, logic [5:0] len,
                      logic [7:0] c1, logic [7:0] c2, logic [4:0] w, logic [31:0] num,
                      logic [17:0] h, logic tl);
    tok_t t;
    t = '0;
    t.kind = k; t.start_row = r; t.start_col = c; t.lexeme_length = len;
    t.first_char = c1; t.second_char = c2; t.word_index = w; t.number_value = num;
    t.name_hash = h; t.too_long = tl;
    if (step_toks.size() < 2) step_toks.push_back(t);
  endtask

  task automatic close_op(logic [3:0] k, logic [7:0] second);
    emit(k, t_row, t_col, second != 0 ? 6'd2 : 6'd1, t_first, second, WORD_NONE, 0, 0, 0);
    p_mode = MODE_IDLE;
  endtask

  function automatic bit lengthen();
    if (t_len < MAX_LEXEME) begin
      t_len++;
      return 1'b1;
    end
    t_over = 1'b1;
    return 1'b0;
  endfunction

  task automatic take_digit(logic [7:0] c);
    logic [35:0] v;
    bit ok;
    v = t_num * 36'd10 + (c - "0");
    ok = lengthen();
    if (v > 36'hFFFFFFFF) begin
      t_num = '1;
      t_over = 1'b1;
    end else begin
      t_num = v[31:0];
    end
  endtask

  task automatic take_letter(logic [7:0] c);
    int p;
    int h;
    p = t_len;
    if (!lengthen()) begin
      t_alive = '0;
      return;
    end
    for (int w = 0; w < 17; w++)
      if (p >= kw_names[w].len() || kw_names[w][p] != c) t_alive[w] = 1'b0;
    h = t_hash + c * primes_tab[p % 64];
    t_hash = h > 262143 ? HASH_MAX : h[17:0];
  endtask

  task automatic finish_token();
    int found;
    found = 17;
    case (p_mode)
      MODE_ADDSUB, MODE_MULMOD, MODE_SLASH: close_op(KIND_ARITH, 0);
      MODE_ANDOR, MODE_BANG: close_op(KIND_LOGIC, 0);
      MODE_LTGT: close_op(KIND_REL, 0);
      MODE_EQ: close_op(KIND_ASSIGN, 0);
      MODE_NUM: emit(KIND_NUM, t_row, t_col, t_len, t_first, 0, WORD_NONE, t_num, 0, t_over);
      MODE_IDENT: begin
        if (!t_over)
          for (int w = 0; w < 17; w++)
            if (found == 17 && t_alive[w] && kw_names[w].len() == t_len) found = w;
        if (found == 17)
          emit(KIND_IDENT, t_row, t_col, t_len, t_first, 0, WORD_NONE, 0, t_hash, t_over);
        else
          emit(found < 13 ? KIND_KEYWORD : KIND_TYPE, t_row, t_col, t_len, t_first, 0,
               found[4:0], 0, 0, t_over);
      end
      MODE_STR: emit(KIND_STRING, t_row, t_col, t_len, "\"", 0, WORD_NONE, 0, 0, t_over);
      default: ;
    endcase
    p_mode = MODE_IDLE;
  endtask

  task automatic open_token(logic [7:0] c, logic [15:0] r, logic [15:0] col);
    t_row = r; t_col = col; t_first = c; t_len = 0; t_num = 0; t_hash = 0;
    t_alive = '1; t_over = 0;
    p_mode = MODE_IDLE;
    case (c)
      "\n": emit(KIND_NEWLINE, r, col, 1, "\n", 0, WORD_NONE, 0, 0, 0);
      "/": p_mode = MODE_SLASH;
      "#": p_mode = MODE_LINE;
      "\"": p_mode = MODE_STR;
      ";", ",", ":", "(", ")", "{", "}", "[", "]":
        emit(KIND_SPECIAL, r, col, 1, c, 0, WORD_NONE, 0, 0, 0);
      "+", "-": p_mode = MODE_ADDSUB;
      "*", "%": p_mode = MODE_MULMOD;
      "&", "|": p_mode = MODE_ANDOR;
      "!": p_mode = MODE_BANG;
      "<", ">": p_mode = MODE_LTGT;
      "=": p_mode = MODE_EQ;
      default: begin
        if (digit_c(c)) begin
          p_mode = MODE_NUM;
          take_digit(c);
        end else if (word_c(c)) begin
          p_mode = MODE_IDENT;
          take_letter(c);
        end
      end
    endcase
  endtask

  task automatic clear_scan();
    p_mode = MODE_IDLE; p_row = 1; p_col = 1; t_row = 1; t_col = 1; t_len = 0;
    t_first = 0; t_num = 0; t_hash = 0; t_alive = '1; t_over = 0;
  endtask

  // Works out the tokens that one accepted byte causes and queues them.
  task automatic predict_tokens(logic [7:0] c, logic eoi);
    logic [15:0] r, col;
    int inc;
    bit ok;
    r = p_row; col = p_col;
    step_toks.delete();
    if (eoi) begin
      finish_token();
      emit(KIND_END, r, col, 0, 0, 0, WORD_NONE, 0, 0, 0);
      clear_scan();
    end else begin
      case (p_mode)
        MODE_IDLE: open_token(c, r, col);
        MODE_ADDSUB:
          if (c == t_first || c == "=") close_op(KIND_ARITH, c);
          else begin finish_token(); open_token(c, r, col); end
        MODE_MULMOD:
          if (c == "=") close_op(KIND_ARITH, c);
          else begin finish_token(); open_token(c, r, col); end
        MODE_SLASH:
          if (c == "/") p_mode = MODE_LINE;
          else if (c == "*") p_mode = MODE_BLOCK;
          else if (c == "=") close_op(KIND_ARITH, c);
          else begin finish_token(); open_token(c, r, col); end
        MODE_ANDOR:
          if (c == t_first) close_op(KIND_LOGIC, c);
          else begin finish_token(); open_token(c, r, col); end
        MODE_BANG, MODE_LTGT, MODE_EQ:
          if (c == "=") close_op(KIND_REL, c);
          else begin finish_token(); open_token(c, r, col); end
        MODE_NUM:
          if (digit_c(c)) take_digit(c);
          else begin finish_token(); open_token(c, r, col); end
        MODE_IDENT:
          if (word_c(c)) take_letter(c);
          else begin finish_token(); open_token(c, r, col); end
        MODE_STR:
          if (c == "\"") finish_token();
          else ok = lengthen();
        MODE_LINE: if (c == "\n") p_mode = MODE_IDLE;
        MODE_BLOCK: if (c == "*") p_mode = MODE_BSTAR;
        MODE_BSTAR:
          if (c == "/") p_mode = MODE_IDLE;
          else if (c != "*") p_mode = MODE_BLOCK;
        default: open_token(c, r, col);
      endcase
      if (c == "\n") begin
        if (p_row != POS_MAX) p_row++;
        p_col = 1;
      end else begin
        inc = (c == "\t") ? tabs_now : 1;
        p_col = (p_col + inc > 65535) ? POS_MAX : p_col + inc;
      end
    end
    if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last_of_run = 1'b1;
    foreach (step_toks[i]) token_queue.push_back(step_toks[i]);
  endtask

  function automatic bit stall_now();
    return !idle_free && $urandom_range(99) < 17;
  endfunction

  // Byte driver.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) predict_tokens(ch, end_of_input);
      if (byte_queue.size() > 0 && !stall_now()) begin
        in_valid <= 1'b1;
        ch <= byte_queue[0].ch;
        end_of_input <= byte_queue[0].eoi;
        void'(byte_queue.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Configuration write driver.
  always @(posedge clk) begin
    if (rst) begin
      cfg_valid <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      cfg_valid <= 1'b0;
      cfg_pending <= 1'b0;
      tabs_now <= tab_width;
    end else if (cfg_pending && !cfg_valid) begin
      cfg_valid <= 1'b1;
      tab_width <= cfg_value;
    end
  end

  // Token monitor.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        tok_t got, want;
        got = '{kind, start_row, start_col, lexeme_length, first_char, second_char,
                word_index, number_value, name_hash, too_long, last_of_run};
        if (token_queue.size() == 0) begin
          n_bad++;
          if (n_bad <= 10) $display("unexpected token %p", got);
        end else begin
          want = token_queue.pop_front();
          if (got !== want) begin
            n_bad++;
            if (n_bad <= 10) $display("token mismatch: expected %p, got %p", want, got);
          end
        end
      end
      out_ready <= !stall_now();
    end
  end

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) byte_queue.push_back('{s[i], 1'b0});
  endtask

  task automatic push_end();
    byte_queue.push_back('{8'd0, 1'b1});
  endtask

  // Waits until every queued byte is through and every token has come out.
  task automatic drain();
    do @(posedge clk); while (byte_queue.size() > 0 || in_valid);
    do @(posedge clk); while (token_queue.size() > 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_tabs(logic [3:0] v);
    cfg_value = v;
    cfg_pending = 1'b1;
    do @(posedge clk); while (cfg_pending);
  endtask

  function automatic string random_lexeme();
    string s;
    int n;
    case ($urandom_range(15))
      0: s = kw_names[$urandom_range(16)];
      1: begin
        n = $urandom_range(1, 10);
        if ($urandom_range(9) == 0) n = $urandom_range(33, 40);
        s = "";
        for (int i = 0; i < n; i++) s = {s, string'(byte'(i == 0 ? "a" + $urandom_range(25)
              : id_chars[$urandom_range(3)] + ($urandom_range(1) ? 0 : 1)))};
      end
      2: begin
        n = $urandom_range(1, 6);
        if ($urandom_range(7) == 0) n = $urandom_range(10, 36);
        s = "";
        for (int i = 0; i < n; i++) s = {s, string'(byte'("0" + $urandom_range(9)))};
      end
      3: s = "\"s t\"";
      4: s = "// note\n";
      5: s = "/* x * y **/";
      6: s = "# define\n";
      7: s = "\n";
      8: s = "\t";
      9: s = " ";
      10: s = string'(byte'(op_chars[$urandom_range(10)]));
      11: s = string'(byte'(sym_chars[$urandom_range(8)]));
      12: s = {string'(byte'(op_chars[$urandom_range(10)])),
               string'(byte'(op2_chars[$urandom_range(4)]))};
      13: s = string'(byte'($urandom_range(1, 255)));
      14: s = "\"unterminated";
      default: s = "x1 = y2;";
    endcase
    return s;
  endfunction

  initial begin
    clear_scan();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: operators, words, numbers, comments, strings and saturation.
    push_text("if(a<=b)x+=1;else y=!z!=c==d/e/=f;\n");
    push_text("int float double char printf_ abc123 while\t9 //c\n#x\n/*a**/");
    push_text("a&&b||c&d|e++ --%=*=>>=;\"st\" 4294967295 4294967296 ");
    push_text("abcdefghijklmnopqrstuvwxyzABCDEFGHIJ ");
    byte_queue.push_back('{8'hFF, 1'b0});
    byte_queue.push_back('{8'h00, 1'b0});
    push_text("\"open");
    push_end();
    push_text("/* open");
    push_end();
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      int count;
      write_tabs(phase == 0 ? 4'd1 : phase == 1 ? 4'd8 : phase == 2 ? 4'd0 :
                 phase == 3 ? 4'd15 : 4'($urandom_range(2, 7)));
      idle_free = (phase == 2);
      count = 0;
      while (count < 65) begin
        string s;
        s = random_lexeme();
        push_text(s);
        count += s.len();
        if ($urandom_range(3) == 0) push_text(" ");
      end
      if ($urandom_range(1) == 0) push_end();
      drain();
    end
    idle_free = 1'b0;
    push_end();
    drain();

    if (n_bad == 0) begin
      $display("c_subset_lexical_scanner: match");
    end else begin
      $display("c_subset_lexical_scanner: mismatch");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("c_subset_lexical_scanner: mismatch");
    $finish;
  end
endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/csls_pkg.sv
rtl/core/csls_front.sv
rtl/core/csls_queue.sv
rtl/core/csls_back.sv
rtl/core/c_subset_lexical_scanner.sv
sim/c_subset_lexical_scanner_test.sv
